// ===== hw/rtl/mersenne_twister_generator_defines.svh =====
// Assertion macros shared by the generator RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// cond must never hold outside reset
`define MT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define MT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define MT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mt_pkg.sv =====
package mt_pkg;

    localparam int unsigned POOL_WORDS   = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned ADDR_W       = 10;
    localparam int unsigned WORD_W       = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam addr_t LAST_POS = ADDR_W'(POOL_WORDS - 1);
    localparam addr_t FAR_STEP = ADDR_W'(TWIST_OFFSET);
    localparam addr_t FAR_WRAP = ADDR_W'(POOL_WORDS - TWIST_OFFSET);

    localparam word_t HIGH_BIT  = 32'h8000_0000;
    localparam word_t LOW_BITS  = 32'h7FFF_FFFF;
    localparam word_t TWIST_XOR = 32'h9908_B0DF;
    localparam word_t TEMPER_B  = 32'h9D2C_5680;
    localparam word_t TEMPER_C  = 32'hEFC6_0000;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } action_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        word_t data;
    } mt_wr_t;

    function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
        word_t y;
        word_t v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TWIST_XOR;
        end
        return v;
    endfunction

    function automatic word_t temper(word_t r);
        word_t t;
        t = r ^ (r >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

// ===== hw/rtl/mersenne_twister_generator.sv =====
// 32-bit MT19937 word generator with a 624-word state pool.
// Input channel (in_valid / in_stall) carries one word per item: action 0 loads
// seed_word into the pool at seed_addr (dropped when seed_addr >= 624) and
// restarts the pass at position 0; action 1 draws one tempered word.
// Output channel (out_valid / out_stall) returns random_value, one per draw;
// loads return nothing.
// The input takes no new item while the last one is in S1, since pool read port
// A serves the current word and then the twist-offset word of each draw. The
// twist is done word by word as the pass is read. A load that arrives part way
// into a remixed pass is held off while the rest of the pool is remixed.
// A draw moves through S1, S2 and S3 and its tempered word is pushed into the
// output queue from S3. A 2-word output queue decouples the sides; when the
// receiver stalls, up to two words wait there and the input stalls only once no
// room is left for the words still in flight.
// Reset clears the read position and sets the fresh-pass flag; the pool has no
// reset and must be loaded before it is drawn from.
module mersenne_twister_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          action,
    input  mt_pkg::addr_t seed_addr,
    input  mt_pkg::word_t seed_word,
    output logic          out_valid,
    input  logic          out_stall,
    output mt_pkg::word_t random_value
);
    import mt_pkg::*;

    `include "mersenne_twister_generator_defines.svh"

    typedef struct packed {
        logic  vld;
        logic  draw;
        logic  twist;
        addr_t k;
        addr_t far;
        addr_t addr;
        word_t word;
    } stage_t;

    addr_t  pos_reg;
    addr_t  pos_next;
    logic   fresh_reg;
    logic   fresh_next;
    stage_t s1_reg;
    stage_t s1_next;
    stage_t s2_reg;
    stage_t s3_reg;
    word_t  s3_cur_reg;
    word_t  s3_nxt_reg;

    logic       accept;
    logic       flush_need;
    logic       pop;
    logic [1:0] level;
    logic [2:0] pending;
    addr_t      nxt_addr;
    addr_t      rd_a_addr;
    word_t      rd_a_data;
    word_t      rd_b_data;
    mt_wr_t     wr;
    logic       load_wr;
    logic       twist_wr;
    word_t      new_word;
    logic       push;
    word_t      push_data;

    // a load mid-pass of a remixed pool waits until the remaining words are remixed
    assign flush_need = in_valid && (action_t'(action) == ACT_LOAD) && !fresh_reg
                        && (pos_reg != '0);

    // words that will sit in the output queue once the draws in S2 and S3 land
    assign pop     = out_valid && !out_stall;
    assign pending = 3'(s2_reg.vld && s2_reg.draw) + 3'(s3_reg.vld && s3_reg.draw)
                     + 3'(level) - 3'(pop);
    assign in_stall = s1_reg.vld || (pending >= 3'd2) || flush_need;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pos_next   = pos_reg;
        fresh_next = fresh_reg;
        s1_next      = '0;
        s1_next.addr = seed_addr;
        s1_next.word = seed_word;
        s1_next.k    = pos_reg;
        s1_next.far  = (pos_reg < FAR_WRAP) ? pos_reg + FAR_STEP : pos_reg - FAR_WRAP;
        if (flush_need && !s1_reg.vld)
        begin
            // remix-only slot, nothing is returned
            s1_next.vld   = 1'b1;
            s1_next.twist = 1'b1;
            pos_next      = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
        else if (accept)
        begin
            s1_next.vld = 1'b1;
            case (action_t'(action))
                ACT_LOAD:
                begin
                    pos_next   = '0;
                    fresh_next = 1'b1;
                end
                ACT_DRAW:
                begin
                    s1_next.draw  = 1'b1;
                    s1_next.twist = !fresh_reg;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next   = '0;
                        fresh_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    s1_next.vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fresh_reg <= 1'b1;
            s1_reg    <= '0;
            s2_reg    <= '0;
            s3_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            fresh_reg <= fresh_next;
            s1_reg    <= s1_next;
            s2_reg    <= s1_reg;
            s3_reg    <= s2_reg;
        end
    end

    // current and next word arrive during S2
    always_ff @(posedge clk)
    begin
        s3_cur_reg <= rd_a_data;
        s3_nxt_reg <= rd_b_data;
    end

    assign nxt_addr  = (s1_reg.k == LAST_POS) ? '0 : s1_reg.k + 1'b1;
    assign rd_a_addr = s1_reg.vld ? s1_reg.k : s2_reg.far;

    // load writes in S2, twist write-back in S3; spacing keeps them apart
    assign load_wr  = s2_reg.vld && !s2_reg.draw && !s2_reg.twist
                      && (s2_reg.addr <= LAST_POS);
    assign twist_wr = s3_reg.vld && s3_reg.twist;

    assign new_word = s3_reg.twist ? twist_word(s3_cur_reg, s3_nxt_reg, rd_a_data)
                                   : s3_cur_reg;

    always_comb
    begin
        wr.en   = load_wr || twist_wr;
        wr.addr = twist_wr ? s3_reg.k : s2_reg.addr;
        wr.data = twist_wr ? new_word : s2_reg.word;
    end

    assign push      = s3_reg.vld && s3_reg.draw;
    assign push_data = temper(new_word);

    mt_pool_ram u_pool (
        .clk       (clk),
        .wr        (wr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (nxt_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    mt_out_fifo u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .level        (level)
    );

    `MT_ASSERT_NEVER(a_single_writer, clk, rst_n, load_wr && twist_wr,
        "load and twist write-back in the same cycle")
    `MT_ASSERT_IMPLY(a_queue_room, clk, rst_n, push, (level != 2'd2) || pop,
        "output queue overflow")
    `MT_ASSERT_NEXT(a_item_spacing, clk, rst_n, s1_reg.vld, !s1_reg.vld,
        "items closer than two cycles")
    `MT_ASSERT_NEVER(a_pos_range, clk, rst_n, pos_reg > LAST_POS,
        "read position beyond pool")

endmodule

// ===== hw/rtl/mt_pool_ram.sv =====
module mt_pool_ram (
    input  logic           clk,
    input  mt_pkg::mt_wr_t wr,
    input  mt_pkg::addr_t  rd_a_addr,
    input  mt_pkg::addr_t  rd_b_addr,
    output mt_pkg::word_t  rd_a_data,
    output mt_pkg::word_t  rd_b_data
);
    import mt_pkg::*;

    word_t pool_reg [POOL_WORDS];
    word_t rd_a_data_reg;
    word_t rd_b_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pool_reg[wr.addr] <= wr.data;
        end
        rd_a_data_reg <= pool_reg[rd_a_addr];
        rd_b_data_reg <= pool_reg[rd_b_addr];
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

// ===== hw/rtl/mt_out_fifo.sv =====
module mt_out_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mt_pkg::word_t push_data,
    output logic          out_valid,
    input  logic          out_stall,
    output mt_pkg::word_t random_value,
    output logic [1:0]    level
);
    import mt_pkg::*;

    word_t      data_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop = (count_reg != 2'd0) && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid    = (count_reg != 2'd0);
    assign random_value = data_reg[rd_ptr_reg];
    assign level        = count_reg;

endmodule

// ===== tb/tb_mersenne_twister_generator.sv =====
module tb_mersenne_twister_generator;
    import mt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 60;
    localparam int TAIL_CYCLES = 20;
    localparam int SEED_WORDS  = 128;

    typedef struct {
        action_t act;
        addr_t   addr;
        word_t   word;
        int      gap;
        bit      drain_first;
    } stim_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    logic  action    = 1'b0;
    addr_t seed_addr = '0;
    word_t seed_word = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t random_value;

    mersenne_twister_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .seed_addr    (seed_addr),
        .seed_word    (seed_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    always #5 clk = ~clk;

    // generator copy
    word_t       pool_copy [POOL_WORDS];
    int unsigned draw_pos;
    bit          seeds_fresh;
    word_t       expected_words [$];

    // sender state
    stim_t pending [$];
    stim_t staged_item;
    bit    staged;
    int    gap_left;
    bit    valid_next;
    int    stim_serial;
    bit    tx_fast;
    int    draws_since_load;

    // receiver state
    int    got_count;
    int    stall_left;
    int    hold_left;
    bit    hold_done;
    bit    rx_fast;
    bit    stall_next;
    word_t want;

    int    fail_count;
    int    cycle_count;

    task automatic predict_word(logic act, addr_t a, word_t w);
        word_t       y;
        word_t       r;
        int unsigned nxt_k;
        int unsigned far_k;
        if (act == ACT_LOAD)
        begin
            if (a < POOL_WORDS)
                pool_copy[a] = w;
            draw_pos    = 0;
            seeds_fresh = 1'b1;
        end
        else
        begin
            // a new pass after a full one remixes the pool in place, ascending
            if (draw_pos == 0 && !seeds_fresh)
            begin
                for (int k = 0; k < POOL_WORDS; k++)
                begin
                    nxt_k = (k + 1) % POOL_WORDS;
                    far_k = (k + TWIST_OFFSET) % POOL_WORDS;
                    y = (pool_copy[k] & HIGH_BIT) | (pool_copy[nxt_k] & LOW_BITS);
                    pool_copy[k] = pool_copy[far_k] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
                end
            end
            r = pool_copy[draw_pos];
            r = r ^ (r >> 11);
            r = r ^ ((r << 7) & TEMPER_B);
            r = r ^ ((r << 15) & TEMPER_C);
            r = r ^ (r >> 18);
            expected_words.push_back(r);
            draw_pos++;
            if (draw_pos >= POOL_WORDS)
            begin
                draw_pos    = 0;
                seeds_fresh = 1'b0;
            end
        end
    endtask

    task automatic add_item(action_t act, addr_t a, word_t w, bit drain);
        stim_t it;
        if (stim_serial % 32 == 0)
            tx_fast = ($urandom_range(0, 3) == 0);
        stim_serial++;
        if (act == ACT_LOAD)
            draws_since_load = 0;
        else
            draws_since_load++;
        it.act         = act;
        it.addr        = a;
        it.word        = w;
        it.gap         = tx_fast ? 0 : $urandom_range(0, 15);
        it.drain_first = drain;
        pending.push_back(it);
    endtask

    task automatic add_draws(int n);
        for (int i = 0; i < n; i++)
            add_item(ACT_DRAW, addr_t'($urandom()), $urandom(), 1'b0);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            staged   = 1'b0;
            gap_left = 0;
        end
        else
        begin
            valid_next = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_word(action, seed_addr, seed_word);
                valid_next = 1'b0;
            end
            if (!valid_next)
            begin
                if (!staged && pending.size() > 0)
                begin
                    staged_item = pending.pop_front();
                    staged      = 1'b1;
                    gap_left    = staged_item.gap;
                end
                if (staged)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else if (!staged_item.drain_first || expected_words.size() == 0)
                    begin
                        action     <= staged_item.act;
                        seed_addr  <= staged_item.addr;
                        seed_word  <= staged_item.word;
                        valid_next = 1'b1;
                        staged     = 1'b0;
                    end
                end
            end
            in_valid <= valid_next;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            got_count  = 0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
            rx_fast    = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("random_value: unexpected word %08h", random_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (random_value !== want)
                    begin
                        $error("random_value: expected %08h, got %08h", want, random_value);
                        fail_count++;
                    end
                end
                got_count++;
                if (got_count % 40 == 0)
                    rx_fast = ($urandom_range(0, 2) == 0);
                stall_left = rx_fast ? 0 : $urandom_range(0, 15);
                // one long hold-off mid-run so the block backs up into its input
                if (got_count == HOLD_AT && !hold_done)
                begin
                    hold_left = LONG_HOLD;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            out_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int sel;
        draw_pos         = 0;
        seeds_fresh      = 1'b1;
        fail_count       = 0;
        cycle_count      = 0;
        stim_serial      = 0;
        tx_fast          = 1'b0;
        draws_since_load = 0;

        // low words are seeded first; draws never run past them
        for (int i = 0; i < SEED_WORDS; i++)
            add_item(ACT_LOAD, addr_t'(i),
                     (i == 0) ? word_t'(0) : (i == SEED_WORDS - 1) ? '1 : word_t'($urandom()),
                     1'b0);

        // fresh pass tempers raw seeds
        add_draws(3);
        // load mid-pass restarts at word 0
        add_item(ACT_LOAD, LAST_POS, '0, 1'b0);
        add_draws(2);
        // out-of-range addresses: write dropped, pass still restarts
        add_item(ACT_LOAD, addr_t'(POOL_WORDS), $urandom(), 1'b0);
        add_item(ACT_LOAD, '1, '1, 1'b0);
        add_item(ACT_DRAW, '0, '0, 1'b1);
        add_item(ACT_LOAD, '0, '1, 1'b0);
        add_draws(1);
        add_item(ACT_LOAD, addr_t'(1), HIGH_BIT, 1'b0);
        add_item(ACT_LOAD, addr_t'(2), LOW_BITS, 1'b0);
        add_draws(3);

        // long run of draws from word 0, backs up under the long hold-off
        add_item(ACT_LOAD, addr_t'(5), $urandom(), 1'b0);
        add_draws(SEED_WORDS - 1);

        // random mix of loads and draws
        for (int i = 0; i < 180; i++)
        begin
            sel = $urandom_range(0, 9);
            if (draws_since_load >= SEED_WORDS - 1)
                add_item(ACT_LOAD, addr_t'($urandom_range(0, POOL_WORDS - 1)),
                         $urandom(), 1'b0);
            else if (sel < 2)
                add_item(ACT_LOAD,
                         ($urandom_range(0, 7) == 0) ?
                             addr_t'($urandom_range(POOL_WORDS, 1023)) :
                             addr_t'($urandom_range(0, POOL_WORDS - 1)),
                         $urandom(), 1'b0);
            else if (sel == 2 && $urandom_range(0, 15) == 0)
                add_item(ACT_DRAW, addr_t'($urandom()), $urandom(), 1'b1);
            else
                add_draws(1);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending.size() == 0 && !staged && !in_valid && expected_words.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mt_pkg.sv
hw/rtl/mt_pool_ram.sv
hw/rtl/mt_out_fifo.sv
hw/rtl/mersenne_twister_generator.sv
tb/tb_mersenne_twister_generator.sv
